// ----- rtl/ndt_pkg.sv -----
// ----------------------------------------------------------------------------
// ndt_pkg
// Shared types, constants and helper functions for the network description
// tokenizer.
// ----------------------------------------------------------------------------
package ndt_pkg;

   localparam int POS_W                 = 16;
   localparam int BYTE_W                = 8;
   localparam int KIND_W                = 4;
   localparam int LEN_W                 = 8;
   localparam int DEFAULT_MAX_VALUE_LEN = 255;
   localparam int QUEUE_DEPTH           = 4;
   localparam int QPTR_W                = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W                = $clog2(QUEUE_DEPTH + 1);

   localparam logic [POS_W-1:0] POS_MAX = '1;
   localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

   localparam logic [BYTE_W-1:0] CH_TAB           = 8'h09;
   localparam logic [BYTE_W-1:0] CH_NEWLINE       = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_QUOTE         = 8'h22;
   localparam logic [BYTE_W-1:0] CH_HASH          = 8'h23;
   localparam logic [BYTE_W-1:0] CH_OPEN_PAREN    = 8'h28;
   localparam logic [BYTE_W-1:0] CH_CLOSE_PAREN   = 8'h29;
   localparam logic [BYTE_W-1:0] CH_COMMA         = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_COLON         = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_OPEN_BRACKET  = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_BACKSLASH     = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_CLOSE_BRACKET = 8'h5D;
   localparam logic [BYTE_W-1:0] CH_UNDERSCORE    = 8'h5F;
   localparam logic [BYTE_W-1:0] CH_DIGIT_0       = 8'h30;
   localparam logic [BYTE_W-1:0] CH_DIGIT_9       = 8'h39;
   localparam logic [BYTE_W-1:0] CH_UPPER_A       = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UPPER_Z       = 8'h5A;
   localparam logic [BYTE_W-1:0] CH_LOWER_A       = 8'h61;
   localparam logic [BYTE_W-1:0] CH_LOWER_Z       = 8'h7A;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_LABEL,
      MODE_NUMBER,
      MODE_STRING,
      MODE_COMMENT
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_LABEL       = 4'd0,
      KIND_STRING      = 4'd1,
      KIND_NUMBER      = 4'd2,
      KIND_NEWLINE     = 4'd3,
      KIND_COMMA       = 4'd4,
      KIND_COLON       = 4'd5,
      KIND_TAB         = 4'd6,
      KIND_OPEN_PAREN  = 4'd7,
      KIND_CLOSE_PAREN = 4'd8,
      KIND_OPEN_BRKT   = 4'd9,
      KIND_CLOSE_BRKT  = 4'd10
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [POS_W-1:0]     line;
      logic [POS_W-1:0]     column;
      logic [BYTE_W-1:0]    value;
      logic                 present;
      logic                 done;
   } result_type;

   typedef struct packed {
      logic [1:0]  count;
      result_type  first;
      result_type  second;
   } push_type;

   function automatic logic is_alpha(input logic [BYTE_W-1:0] c);
      return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
             ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
   endfunction

   function automatic logic is_digit(input logic [BYTE_W-1:0] c);
      return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
   endfunction

   function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
      return (v == POS_MAX) ? v : v + POS_ONE;
   endfunction

endpackage

// ----- rtl/ndt_if.sv -----
// ----------------------------------------------------------------------------
// ndt_if
// Valid/ready channel interfaces for text bytes in and tokens out.
// ----------------------------------------------------------------------------
interface ndt_req_if
   import ndt_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ndt_rsp_if
   import ndt_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] token_kind;
   logic [POS_W-1:0]  start_line;
   logic [POS_W-1:0]  start_column;
   logic [BYTE_W-1:0] value_byte;
   logic              byte_present;
   logic              token_done;

   modport source (output valid, output token_kind, output start_line,
                   output start_column, output value_byte, output byte_present,
                   output token_done, input ready);
   modport sink   (input valid, input token_kind, input start_line,
                   input start_column, input value_byte, input byte_present,
                   input token_done, output ready);
endinterface

// ----- rtl/network_description_tokenizer.sv -----
// ----------------------------------------------------------------------------
// network_description_tokenizer
// Turns a stream of description text bytes into tokens with their start
// line and column.
// ----------------------------------------------------------------------------
// Results: every result of a taken text byte is written into the result
// queue and offered on the result channel from the queue head, in order.
// Throughput: one text byte per cycle; the byte is taken whenever the
// four-entry result queue has at least two free entries.
// Reset: synchronous; the lexer returns to idle at line 1, column 1 and the
// result queue empties.
module network_description_tokenizer
   import ndt_pkg::*;
#(
   parameter int MAX_VALUE_LEN = DEFAULT_MAX_VALUE_LEN
) (
   input  logic      clock,
   input  logic      reset,
   ndt_req_if.sink   req_bus,
   ndt_rsp_if.source rsp_bus
);

   logic     accept;
   logic     space_ok;
   push_type push;

   assign req_bus.ready = space_ok;
   assign accept        = req_bus.valid & space_ok;

   ndt_lexer #(
      .MAX_VALUE_LEN(MAX_VALUE_LEN)
   ) u_lexer (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_bus.text_byte),
      .end_of_text (req_bus.end_of_text),
      .push        (push)
   );

   ndt_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_en  (accept),
      .push     (push),
      .space_ok (space_ok),
      .rsp      (rsp_bus)
   );

endmodule

// ----- rtl/ndt_lexer.sv -----
// ----------------------------------------------------------------------------
// ndt_lexer
// Lexer state and the per-byte decision: mode, position tracking and the
// zero, one or two results that each accepted byte produces.
// ----------------------------------------------------------------------------
module ndt_lexer
   import ndt_pkg::*;
#(
   parameter int MAX_VALUE_LEN = DEFAULT_MAX_VALUE_LEN
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [BYTE_W-1:0] text_byte,
   input  logic              end_of_text,
   output push_type          push
);

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_VALUE_LEN);

   mode_type         mode_ff, mode_in;
   logic [POS_W-1:0] line_ff, line_in;
   logic [POS_W-1:0] column_ff, column_in;
   logic [POS_W-1:0] tok_line_ff, tok_line_in;
   logic [POS_W-1:0] tok_column_ff, tok_column_in;
   logic [LEN_W-1:0] length_ff, length_in;

   logic       do_close;
   logic       do_idle;
   logic       do_value;
   logic       adv_col;
   logic       adv_line;
   logic       second_valid;
   kind_type   open_kind;
   result_type close_res;
   result_type second;

   always_comb begin
      case (mode_ff)
         MODE_STRING: open_kind = KIND_STRING;
         MODE_NUMBER: open_kind = KIND_NUMBER;
         default:     open_kind = KIND_LABEL;
      endcase
   end

   always_comb begin
      mode_in       = mode_ff;
      tok_line_in   = tok_line_ff;
      tok_column_in = tok_column_ff;
      length_in     = length_ff;
      do_close      = 1'b0;
      do_idle       = 1'b0;
      do_value      = 1'b0;
      adv_col       = 1'b0;
      adv_line      = 1'b0;
      second_valid  = 1'b0;
      second        = '0;
      close_res     = '{kind: open_kind, line: tok_line_ff, column: tok_column_ff,
                        value: '0, present: 1'b0, done: 1'b1};

      if (end_of_text) begin
         do_close = (mode_ff == MODE_LABEL) || (mode_ff == MODE_NUMBER) ||
                    (mode_ff == MODE_STRING);
         mode_in  = MODE_IDLE;
      end else begin
         case (mode_ff)
            MODE_LABEL: begin
               if (is_alpha(text_byte) || is_digit(text_byte) ||
                   (text_byte == CH_UNDERSCORE)) begin
                  do_value = 1'b1;
                  adv_col  = 1'b1;
               end else begin
                  do_close = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit(text_byte)) begin
                  do_value = 1'b1;
                  adv_col  = 1'b1;
               end else begin
                  do_close = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            MODE_STRING: begin
               if (text_byte == CH_QUOTE) begin
                  do_close = 1'b1;
                  adv_col  = 1'b1;
               end else if (text_byte == CH_NEWLINE) begin
                  do_close = 1'b1;
                  do_idle  = 1'b1;
               end else begin
                  do_value = 1'b1;
                  adv_col  = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (text_byte == CH_NEWLINE) begin
                  mode_in  = MODE_IDLE;
                  adv_line = 1'b1;
               end else begin
                  adv_col = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
               do_idle = 1'b1;
            end
         endcase
      end

      if (do_close) begin
         mode_in = MODE_IDLE;
      end

      if (do_value && (length_ff < MAX_LEN)) begin
         length_in    = length_ff + LEN_W'(1);
         second_valid = 1'b1;
         second       = '{kind: open_kind, line: tok_line_ff, column: tok_column_ff,
                          value: text_byte, present: 1'b1, done: 1'b0};
      end

      if (do_idle) begin
         second = '{kind: KIND_LABEL, line: line_ff, column: column_ff,
                    value: '0, present: 1'b0, done: 1'b1};
         case (text_byte)
            CH_TAB:           second.kind = KIND_TAB;
            CH_COMMA:         second.kind = KIND_COMMA;
            CH_COLON:         second.kind = KIND_COLON;
            CH_OPEN_PAREN:    second.kind = KIND_OPEN_PAREN;
            CH_CLOSE_PAREN:   second.kind = KIND_CLOSE_PAREN;
            CH_OPEN_BRACKET:  second.kind = KIND_OPEN_BRKT;
            CH_CLOSE_BRACKET: second.kind = KIND_CLOSE_BRKT;
            CH_NEWLINE:       second.kind = KIND_NEWLINE;
            default:          second.kind = KIND_LABEL;
         endcase
         case (text_byte)
            CH_TAB, CH_COMMA, CH_COLON, CH_OPEN_PAREN, CH_CLOSE_PAREN,
            CH_OPEN_BRACKET, CH_CLOSE_BRACKET: begin
               tok_line_in   = line_ff;
               tok_column_in = column_ff;
               length_in     = '0;
               second_valid  = 1'b1;
               adv_col       = 1'b1;
            end
            CH_NEWLINE: begin
               tok_line_in   = line_ff;
               tok_column_in = column_ff;
               length_in     = '0;
               second_valid  = 1'b1;
               adv_line      = 1'b1;
            end
            CH_HASH: begin
               mode_in = MODE_COMMENT;
               adv_col = 1'b1;
            end
            CH_QUOTE: begin
               tok_line_in   = line_ff;
               tok_column_in = column_ff;
               length_in     = '0;
               mode_in       = MODE_STRING;
               adv_col       = 1'b1;
            end
            default: begin
               adv_col = 1'b1;
               if (is_alpha(text_byte) || (text_byte == CH_UNDERSCORE) ||
                   (text_byte == CH_BACKSLASH) || is_digit(text_byte)) begin
                  tok_line_in   = line_ff;
                  tok_column_in = column_ff;
                  length_in     = LEN_W'(1);
                  second_valid  = 1'b1;
                  second.value  = text_byte;
                  second.present = 1'b1;
                  second.done   = 1'b0;
                  if (is_digit(text_byte)) begin
                     mode_in     = MODE_NUMBER;
                     second.kind = KIND_NUMBER;
                  end else begin
                     mode_in     = MODE_LABEL;
                     second.kind = KIND_LABEL;
                  end
               end
            end
         endcase
      end

      line_in   = line_ff;
      column_in = column_ff;
      if (adv_line) begin
         line_in   = sat_inc(line_ff);
         column_in = POS_ONE;
      end else if (adv_col) begin
         column_in = sat_inc(column_ff);
      end

      if (do_close) begin
         push.first  = close_res;
         push.second = second;
         push.count  = second_valid ? 2'd2 : 2'd1;
      end else begin
         push.first  = second;
         push.second = second;
         push.count  = second_valid ? 2'd1 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         line_ff       <= POS_ONE;
         column_ff     <= POS_ONE;
         tok_line_ff   <= POS_ONE;
         tok_column_ff <= POS_ONE;
         length_ff     <= '0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         line_ff       <= line_in;
         column_ff     <= column_in;
         tok_line_ff   <= tok_line_in;
         tok_column_ff <= tok_column_in;
         length_ff     <= length_in;
      end
   end

endmodule

// ----- rtl/ndt_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// ndt_rsp_queue
// Four-entry result queue that takes up to two results per cycle and hands
// out one beat per cycle on the result channel while ready is high.
// ----------------------------------------------------------------------------
module ndt_rsp_queue
   import ndt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_en,
   input  push_type  push,
   output logic      space_ok,
   ndt_rsp_if.source rsp
);

   result_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [1:0]        push_count;
   logic              pop;
   result_type        head;

   assign push_count = push_en ? push.count : 2'd0;
   assign pop        = rsp.valid & rsp.ready;
   assign space_ok   = count_ff <= QCNT_W'(QUEUE_DEPTH - 2);

   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push_count);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign count_in  = count_ff + QCNT_W'(push_count) - QCNT_W'(pop);

   assign head             = entry_ff[rd_ptr_ff];
   assign rsp.valid        = count_ff != '0;
   assign rsp.token_kind   = head.kind;
   assign rsp.start_line   = head.line;
   assign rsp.start_column = head.column;
   assign rsp.value_byte   = head.value;
   assign rsp.byte_present = head.present;
   assign rsp.token_done   = head.done;

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_ff + QPTR_W'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- tb/sv/tb_network_description_tokenizer.sv -----
// ----------------------------------------------------------------------------
// tb_network_description_tokenizer
// Streams description text through the tokenizer with random gaps on both
// channels and a long result stall. A lexer model in the scoreboard predicts
// every token beat, and each beat is compared field by field in order. The
// stimulus covers every token kind and value overflow.
// ----------------------------------------------------------------------------
module tb_network_description_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;
   import ndt_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1750;
   localparam int unsigned HOLD_AT_BEAT = 150;
   localparam int unsigned HOLD_CYCLES  = 250;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned MAX_REPORTS  = 100;
   localparam int unsigned TIMEOUT_NS   = 10_000_000;

   class token_scoreboard;
      mode_type          lex_state;
      logic [POS_W-1:0]  line_now;
      logic [POS_W-1:0]  column_now;
      logic [POS_W-1:0]  token_line;
      logic [POS_W-1:0]  token_column;
      int unsigned       kept_bytes;
      result_type        expected_tokens[$];
      int unsigned       error_count;

      function new();
         lex_state    = MODE_IDLE;
         line_now     = POS_ONE;
         column_now   = POS_ONE;
         token_line   = POS_ONE;
         token_column = POS_ONE;
         kept_bytes   = 0;
         error_count  = 0;
      endfunction

      task report(string what);
         error_count++;
         if (error_count <= MAX_REPORTS) begin
            $display("ERROR: %s", what);
         end
      endtask

      function bit is_letter(logic [BYTE_W-1:0] c);
         return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                (c >= CH_LOWER_A && c <= CH_LOWER_Z);
      endfunction

      function bit is_numeral(logic [BYTE_W-1:0] c);
         return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
      endfunction

      function void push_token(kind_type kind, logic [BYTE_W-1:0] value, logic present);
         result_type r;
         r.kind    = kind;
         r.line    = token_line;
         r.column  = token_column;
         r.value   = value;
         r.present = present;
         r.done    = !present;
         expected_tokens.push_back(r);
      endfunction

      function void step_column();
         if (column_now != POS_MAX) begin
            column_now++;
         end
      endfunction

      function void step_line();
         if (line_now != POS_MAX) begin
            line_now++;
         end
         column_now = POS_ONE;
      endfunction

      function void anchor_token();
         token_line   = line_now;
         token_column = column_now;
         kept_bytes   = 0;
      endfunction

      function kind_type value_kind();
         case (lex_state)
            MODE_STRING: return KIND_STRING;
            MODE_NUMBER: return KIND_NUMBER;
            default:     return KIND_LABEL;
         endcase
      endfunction

      function void append_byte(logic [BYTE_W-1:0] c);
         if (kept_bytes < DEFAULT_MAX_VALUE_LEN) begin
            kept_bytes++;
            push_token(value_kind(), c, 1'b1);
         end
      endfunction

      function void end_value();
         push_token(value_kind(), '0, 1'b0);
         lex_state = MODE_IDLE;
      endfunction

      function void punct_token(kind_type kind);
         anchor_token();
         push_token(kind, '0, 1'b0);
         step_column();
      endfunction

      function void start_text(logic [BYTE_W-1:0] c);
         case (c)
            CH_TAB:           punct_token(KIND_TAB);
            CH_COMMA:         punct_token(KIND_COMMA);
            CH_COLON:         punct_token(KIND_COLON);
            CH_OPEN_PAREN:    punct_token(KIND_OPEN_PAREN);
            CH_CLOSE_PAREN:   punct_token(KIND_CLOSE_PAREN);
            CH_OPEN_BRACKET:  punct_token(KIND_OPEN_BRKT);
            CH_CLOSE_BRACKET: punct_token(KIND_CLOSE_BRKT);
            CH_NEWLINE: begin
               anchor_token();
               push_token(KIND_NEWLINE, '0, 1'b0);
               step_line();
            end
            CH_HASH: begin
               lex_state = MODE_COMMENT;
               step_column();
            end
            CH_QUOTE: begin
               anchor_token();
               lex_state = MODE_STRING;
               step_column();
            end
            default: begin
               if (is_letter(c) || c == CH_UNDERSCORE || c == CH_BACKSLASH) begin
                  anchor_token();
                  lex_state = MODE_LABEL;
                  append_byte(c);
               end else if (is_numeral(c)) begin
                  anchor_token();
                  lex_state = MODE_NUMBER;
                  append_byte(c);
               end
               step_column();
            end
         endcase
      endfunction

      function void note_text(logic [BYTE_W-1:0] c, logic eot);
         if (eot) begin
            if (lex_state == MODE_LABEL || lex_state == MODE_NUMBER ||
                lex_state == MODE_STRING) begin
               end_value();
            end
            lex_state = MODE_IDLE;
            return;
         end
         case (lex_state)
            MODE_LABEL: begin
               if (is_letter(c) || is_numeral(c) || c == CH_UNDERSCORE) begin
                  append_byte(c);
                  step_column();
               end else begin
                  end_value();
                  start_text(c);
               end
            end
            MODE_NUMBER: begin
               if (is_numeral(c)) begin
                  append_byte(c);
                  step_column();
               end else begin
                  end_value();
                  start_text(c);
               end
            end
            MODE_STRING: begin
               if (c == CH_QUOTE) begin
                  end_value();
                  step_column();
               end else if (c == CH_NEWLINE) begin
                  end_value();
                  start_text(c);
               end else begin
                  append_byte(c);
                  step_column();
               end
            end
            MODE_COMMENT: begin
               if (c == CH_NEWLINE) begin
                  lex_state = MODE_IDLE;
                  step_line();
               end else begin
                  step_column();
               end
            end
            default: begin
               lex_state = MODE_IDLE;
               start_text(c);
            end
         endcase
      endfunction

      task check_token(result_type got);
         result_type want;
         if (expected_tokens.size() == 0) begin
            report($sformatf("token beat with none expected: kind %0d line %0d column %0d",
                             got.kind, got.line, got.column));
            return;
         end
         want = expected_tokens.pop_front();
         if (got.kind !== want.kind || got.line !== want.line ||
             got.column !== want.column || got.value !== want.value ||
             got.present !== want.present || got.done !== want.done) begin
            report($sformatf("token beat %0d/%0d/%0d/%02h/%0b/%0b, expected %0d/%0d/%0d/%02h/%0b/%0b",
                             got.kind, got.line, got.column, got.value, got.present,
                             got.done, want.kind, want.line, want.column, want.value,
                             want.present, want.done));
         end
      endtask
   endclass

   logic            clock = 1'b0;
   logic            reset;
   logic            gaps_on;
   int unsigned     sent_beats = 0;
   token_scoreboard lexer_sb = new();

   ndt_req_if req_bus ();
   ndt_rsp_if rsp_bus ();

   network_description_tokenizer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin : beat_monitor
      result_type beat;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            lexer_sb.note_text(req_bus.text_byte, req_bus.end_of_text);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            beat.kind    = kind_type'(rsp_bus.token_kind);
            beat.line    = rsp_bus.start_line;
            beat.column  = rsp_bus.start_column;
            beat.value   = rsp_bus.value_byte;
            beat.present = rsp_bus.byte_present;
            beat.done    = rsp_bus.token_done;
            lexer_sb.check_token(beat);
         end
      end
   end

   function automatic logic [BYTE_W-1:0] label_start_byte();
      int unsigned r;
      r = $urandom_range(0, 53);
      if (r < 26) begin
         return CH_UPPER_A + BYTE_W'(r);
      end
      if (r < 52) begin
         return CH_LOWER_A + BYTE_W'(r - 26);
      end
      return (r == 52) ? CH_UNDERSCORE : CH_BACKSLASH;
   endfunction

   function automatic logic [BYTE_W-1:0] label_body_byte();
      int unsigned r;
      r = $urandom_range(0, 62);
      if (r < 26) begin
         return CH_UPPER_A + BYTE_W'(r);
      end
      if (r < 52) begin
         return CH_LOWER_A + BYTE_W'(r - 26);
      end
      if (r < 62) begin
         return CH_DIGIT_0 + BYTE_W'(r - 52);
      end
      return CH_UNDERSCORE;
   endfunction

   function automatic logic [BYTE_W-1:0] numeral_byte();
      return CH_DIGIT_0 + BYTE_W'($urandom_range(0, 9));
   endfunction

   function automatic logic [BYTE_W-1:0] string_body_byte();
      logic [BYTE_W-1:0] b;
      do begin
         b = BYTE_W'($urandom);
      end while (b == CH_QUOTE || b == CH_NEWLINE);
      return b;
   endfunction

   // Called and returns at a falling edge.
   task automatic send_text(input logic [BYTE_W-1:0] b, input logic eot);
      int unsigned gap;
      gap = gaps_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.text_byte   <= b;
      req_bus.end_of_text <= eot;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      sent_beats++;
      @(negedge clock);
   endtask

   initial begin : token_sink
      int unsigned taken;
      int unsigned gap;
      bit          held;
      taken = 0;
      held  = 1'b0;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         gap = gaps_on ? $urandom_range(0, 3) : 0;
         if (!held && taken >= HOLD_AT_BEAT) begin
            gap  = HOLD_CYCLES;
            held = 1'b1;
         end
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) begin
            @(posedge clock);
         end
         taken++;
         @(negedge clock);
      end
   end

   initial begin : text_source
      logic [8:0]        opening[$];
      logic [BYTE_W-1:0] b;
      int unsigned       random_base;
      int unsigned       pick;
      reset               = 1'b1;
      gaps_on             = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.text_byte   = '0;
      req_bus.end_of_text = 1'b0;
      opening = '{
         {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, CH_BACKSLASH}, {1'b0, "Z"}, {1'b0, "9"},
         {1'b0, CH_COMMA}, {1'b0, "0"}, {1'b0, "7"}, {1'b0, "a"}, {1'b0, CH_UNDERSCORE},
         {1'b0, CH_OPEN_PAREN}, {1'b0, CH_CLOSE_PAREN}, {1'b0, CH_OPEN_BRACKET},
         {1'b0, CH_CLOSE_BRACKET}, {1'b0, CH_COLON}, {1'b0, CH_TAB}, {1'b0, CH_QUOTE},
         {1'b0, 8'h7F}, {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE}, {1'b0, CH_NEWLINE},
         {1'b0, CH_HASH}, {1'b0, 8'hFF}, {1'b0, CH_NEWLINE}, {1'b0, "5"}, {1'b1, 8'hFF},
         {1'b0, CH_HASH}, {1'b1, 8'h00}, {1'b1, "Z"}
      };
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (opening[i]) begin
         send_text(opening[i][7:0], opening[i][8]);
      end

      gaps_on     = 1'b1;
      random_base = sent_beats;
      send_text(label_start_byte(), 1'b0);
      repeat (299) send_text(label_body_byte(), 1'b0);
      send_text(CH_COMMA, 1'b0);
      repeat (270) send_text(numeral_byte(), 1'b0);
      send_text(" ", 1'b0);
      send_text(CH_QUOTE, 1'b0);
      repeat (262) send_text(string_body_byte(), 1'b0);
      send_text(CH_QUOTE, 1'b0);

      while (sent_beats - random_base < RANDOM_ITEMS) begin
         if ($urandom_range(0, 19) == 0) begin
            gaps_on = !gaps_on;
         end
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            send_text(label_start_byte(), 1'b0);
            repeat ($urandom_range(0, 7)) send_text(label_body_byte(), 1'b0);
         end else if (pick < 40) begin
            repeat ($urandom_range(1, 6)) send_text(numeral_byte(), 1'b0);
         end else if (pick < 53) begin
            send_text(CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 8)) send_text(string_body_byte(), 1'b0);
            case ($urandom_range(0, 9))
               0:       send_text(CH_NEWLINE, 1'b0);
               1:       send_text(BYTE_W'($urandom), 1'b1);
               default: send_text(CH_QUOTE, 1'b0);
            endcase
         end else if (pick < 71) begin
            case ($urandom_range(0, 7))
               0:       b = CH_TAB;
               1:       b = CH_COMMA;
               2:       b = CH_COLON;
               3:       b = CH_OPEN_PAREN;
               4:       b = CH_CLOSE_PAREN;
               5:       b = CH_OPEN_BRACKET;
               6:       b = CH_CLOSE_BRACKET;
               default: b = CH_NEWLINE;
            endcase
            send_text(b, 1'b0);
         end else if (pick < 79) begin
            repeat ($urandom_range(1, 3)) send_text(" ", 1'b0);
         end else if (pick < 85) begin
            send_text(CH_HASH, 1'b0);
            repeat ($urandom_range(0, 6)) begin
               do begin
                  b = BYTE_W'($urandom);
               end while (b == CH_NEWLINE);
               send_text(b, 1'b0);
            end
            if ($urandom_range(0, 7) == 0) begin
               send_text(BYTE_W'($urandom), 1'b1);
            end else begin
               send_text(CH_NEWLINE, 1'b0);
            end
         end else if (pick < 95) begin
            send_text(BYTE_W'($urandom), 1'b0);
         end else begin
            send_text(BYTE_W'($urandom), 1'b1);
         end
      end

      send_text("x", 1'b0);
      send_text(CH_COLON, 1'b0);
      send_text("4", 1'b0);
      send_text(CH_NEWLINE, 1'b0);
      send_text("q", 1'b0);
      send_text(8'h00, 1'b1);
      req_bus.valid <= 1'b0;

      while (lexer_sb.expected_tokens.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (lexer_sb.expected_tokens.size() != 0) begin
         lexer_sb.report("token beats still expected at end of run");
      end
      if (lexer_sb.error_count == 0) begin
         $display("PASS network_description_tokenizer");
      end else begin
         $display("FAIL network_description_tokenizer");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("FAIL network_description_tokenizer");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/ndt_pkg.sv
rtl/ndt_if.sv
rtl/ndt_lexer.sv
rtl/ndt_rsp_queue.sv
rtl/network_description_tokenizer.sv
tb/sv/tb_network_description_tokenizer.sv
